@@ hdl/spar_pkg.sv @@
// ----------------------------------------------------------------------------
// Switch press auto-repeat package
// Shared types and constants for the switch press auto-repeat block.
// ----------------------------------------------------------------------------
package spar_pkg;

    // Per-switch press state.
    typedef enum logic [1:0] {
        PS_IDLE   = 2'd0,
        PS_FIRST  = 2'd1,
        PS_HELD   = 2'd2,
        PS_REPEAT = 2'd3
    } t_press_state;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_NC    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 2'd2;

    // Configuration data width and reset values.
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_DATA_W-1:0] DELAY_RST    = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] INTERVAL_RST = 16'd200;

    // Width of the poll time field on the port.
    localparam int unsigned NOW_W = 32;

    // Result of one state update.
    typedef struct packed {
        logic         fire;
        t_press_state state;
    } t_upd;

endpackage

@@ hdl/spar_update.sv @@
// ----------------------------------------------------------------------------
// Switch press auto-repeat state update
// Computes the next press state and the fire flag for one poll of one switch.
// ----------------------------------------------------------------------------
module spar_update #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  spar_pkg::t_press_state           i_state,
    input  logic [TIME_WIDTH-1:0]            i_start,
    input  logic [TIME_WIDTH-1:0]            i_now,
    input  logic                             i_active,
    input  logic [spar_pkg::CFG_DATA_W-1:0]  i_delay,
    input  logic [spar_pkg::CFG_DATA_W-1:0]  i_interval,
    output spar_pkg::t_upd                   o_upd
);
    import spar_pkg::*;

    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_delay_gone;
    logic                  w_interval_gone;
    t_press_state          w_next;
    logic                  w_fire;

    // Elapsed time wraps at the time width.
    assign w_elapsed       = i_now - i_start;
    assign w_delay_gone    = w_elapsed > TIME_WIDTH'(i_delay);
    assign w_interval_gone = w_elapsed > TIME_WIDTH'(i_interval);

    // Next state.
    always_comb begin
        w_next = i_state;
        if (!i_active) begin
            w_next = PS_IDLE;
        end else begin
            unique case (i_state)
                PS_IDLE:   w_next = PS_FIRST;
                PS_FIRST:  w_next = PS_HELD;
                PS_HELD:   w_next = w_delay_gone ? PS_REPEAT : PS_HELD;
                PS_REPEAT: w_next = PS_REPEAT;
                default:   w_next = PS_IDLE;
            endcase
        end
    end

    // Fire flag; a fire also restarts the timer.
    always_comb begin
        w_fire = 1'b0;
        if (i_active) begin
            unique case (i_state)
                PS_IDLE:   w_fire = 1'b0;
                PS_FIRST:  w_fire = 1'b1;
                PS_HELD:   w_fire = w_delay_gone;
                PS_REPEAT: w_fire = w_interval_gone;
                default:   w_fire = 1'b0;
            endcase
        end
    end

    assign o_upd.fire  = w_fire;
    assign o_upd.state = w_next;

endmodule

@@ hdl/switch_press_auto_repeat.sv @@
// ----------------------------------------------------------------------------
// Switch press auto-repeat
// Turns polls of two switches into key press events with auto-repeat.
// ----------------------------------------------------------------------------
// The block takes one poll per clock when the output side does not stall and
// returns one beat with the fire flag for every poll, registered in the update
// stage and then the output register. The press state and timer start of both
// switches sit in one small synchronous memory; a poll reads its switch's
// entry on acceptance, updates it in the next cycle and writes it back, and a
// poll of the same switch that follows directly picks up the new entry
// through a forwarding register. That single read, update and write-back
// sets the rate of one poll a cycle. Stalls on the output hold the pipeline;
// configuration writes are always taken at once.
module switch_press_auto_repeat #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Poll input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_switch_index,
    input  logic                             i_pin_level,
    input  logic [spar_pkg::NOW_W-1:0]       i_now_ms,
    // Event output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_fire,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spar_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import spar_pkg::*;

    localparam int unsigned WORD_W = TIME_WIDTH + 2;

    // Configuration registers.
    logic                  r_back_nc;
    logic [CFG_DATA_W-1:0] r_delay;
    logic [CFG_DATA_W-1:0] r_interval;

    // State memory: start time above, press state in the two low bits.
    logic [WORD_W-1:0]     r_mem [2];
    logic [1:0]            r_vld;

    // Read side of the memory and forwarding.
    logic [WORD_W-1:0]     r_rd_word;
    logic                  r_rd_vld;
    logic                  r_fwd_hit;
    logic [WORD_W-1:0]     r_fwd_word;

    // Update stage.
    logic                  r_s1_valid;
    logic                  r_s1_sw;
    logic                  r_s1_level;
    logic [TIME_WIDTH-1:0] r_s1_now;

    // Output register.
    logic                  r_out_valid;
    logic                  r_fire;

    logic                  w_accept;
    logic                  w_s1_adv;
    logic [WORD_W-1:0]     w_cur_word;
    t_press_state          w_cur_state;
    logic [TIME_WIDTH-1:0] w_cur_start;
    logic                  w_active;
    t_upd                  w_upd;
    logic [WORD_W-1:0]     w_wr_word;

    // Handshakes.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration write port; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_nc  <= 1'b0;
            r_delay    <= DELAY_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BACK_NC:  r_back_nc  <= i_cfg_data[0];
                CFG_DELAY:    r_delay    <= i_cfg_data;
                CFG_INTERVAL: r_interval <= i_cfg_data;
                default:      r_back_nc  <= r_back_nc;
            endcase
        end
    end

    // Update stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sw    <= i_switch_index;
            r_s1_level <= i_pin_level;
            r_s1_now   <= TIME_WIDTH'(i_now_ms);
        end
    end

    // Memory read on acceptance; a write-back to the same entry in the same
    // cycle is caught by the forwarding register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_word  <= r_mem[i_switch_index];
            r_fwd_word <= w_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (w_accept) begin
            r_rd_vld  <= r_vld[i_switch_index];
            r_fwd_hit <= w_s1_adv && (r_s1_sw == i_switch_index);
        end
    end

    // Memory write-back when the update stage hands its beat on.
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_mem[r_s1_sw] <= w_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_s1_adv) begin
            r_vld[r_s1_sw] <= 1'b1;
        end
    end

    // Current entry: forwarded, stored, or idle when never written.
    always_comb begin
        priority if (r_fwd_hit) begin
            w_cur_word = r_fwd_word;
        end else if (r_rd_vld) begin
            w_cur_word = r_rd_word;
        end else begin
            w_cur_word = {r_rd_word[WORD_W-1:2], PS_IDLE};
        end
    end

    assign w_cur_state = t_press_state'(w_cur_word[1:0]);
    assign w_cur_start = w_cur_word[WORD_W-1:2];

    // Switch 1 may be normally closed; switch 0 is always active low.
    assign w_active = (r_s1_sw && r_back_nc) ? r_s1_level : !r_s1_level;

    spar_update #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_update (
        .i_state    (w_cur_state),
        .i_start    (w_cur_start),
        .i_now      (r_s1_now),
        .i_active   (w_active),
        .i_delay    (r_delay),
        .i_interval (r_interval),
        .o_upd      (w_upd)
    );

    // A fire restarts the timer.
    assign w_wr_word = {(w_upd.fire ? r_s1_now : w_cur_start), w_upd.state};

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_fire <= w_upd.fire;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fire      = r_fire;

`ifndef SYNTHESIS
    // An idle switch never fires.
    a_idle_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_cur_state == PS_IDLE) |-> !w_upd.fire)
        else $error("idle switch fired");

    // A switch in first state fires on an active poll.
    a_first_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_adv && w_cur_state == PS_FIRST && w_active) |=> (o_out_valid && o_fire))
        else $error("second active poll did not fire");

    // A stalled update stage keeps its beat.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_now) && $stable(r_s1_sw)))
        else $error("update stage lost its beat during a stall");

    // A directly following poll of the same switch must use forwarding.
    a_fwd_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_s1_adv && r_s1_sw == i_switch_index) |=> r_fwd_hit)
        else $error("missed forwarding of a write-back");
`endif

endmodule
